@@ design/alfs_pkg.sv @@
// Shared types and constants for the addressable LED frame serializer.
package alfs_pkg;

  // Item kinds carried in the input beat.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_DUTY_ONE  = 1'b0;
  localparam logic REG_DUTY_ZERO = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] DUTY_ONE_RESET  = 8'd82;
  localparam logic [7:0] DUTY_ZERO_RESET = 8'd39;

  // Pixel word layout: green, red, blue, sent MSB first.
  localparam int WORD_BITS = 24;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] row;
    logic [5:0] column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       line_active;
    logic       frame_last;
  } out_beat_t;

endpackage

@@ design/addressable_led_frame_serializer_top.sv @@
// Addressable LED frame serializer: frame store, bit sequencer and output register.
//
// Usage: the input channel (in_valid/in_ready/in_data) carries one command per
// beat: write one pixel, fill every pixel, start a frame, or one bit-period tick.
// Only a tick produces a result beat on the output channel (out_valid/out_ready/
// out_data): the PWM compare value for the bit, a line-active flag and a flag on
// the final bit of the frame. While idle a tick gives duty 0.
// Writes, ticks inside a word, a start during a frame and the tick that ends the
// frame leave the sequencer in its run state; a tick that ends any other pixel
// word, and a start from idle, pass through the fetch and load states (in_ready
// low) while the next word is read from the frame store's registered read port.
// A fill walks the frame store, one pixel a cycle.
// Results appear in the output register on the cycle after the tick is taken.
// After reset the store is cleared by the same walk and in_ready stays low until
// it ends; the duty registers take 82 and 39. If the receiver stalls with a
// result waiting, in_ready falls until that beat is taken, so no result is lost.
// Configuration writes on cfg_write are taken at any time and should be made
// while the block is idle.
module addressable_led_frame_serializer_top #(
  parameter int ROWS         = 16,
  parameter int LEDS_PER_ROW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  alfs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output alfs_pkg::out_beat_t out_data,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import alfs_pkg::*;

  localparam int PIXELS = ROWS * LEDS_PER_ROW;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);
  localparam logic [4:0]    LAST_BIT  = 5'(WORD_BITS - 1);

  // Sequencer states.
  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0]    state;
  logic [AW-1:0] sweep_addr;
  logic [23:0]   fill_color;
  logic [AW-1:0] pix_addr;
  logic [4:0]    bit_counter;
  logic [23:0]   shift_word;
  logic          sending;
  logic [7:0]    duty_one;
  logic [7:0]    duty_zero;

  logic [23:0]   mem [PIXELS];
  logic [23:0]   rd_data;

  logic          accept;
  logic [23:0]   color;
  logic [31:0]   wr_index;
  logic          wr_in_range;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;

  // Commands are taken only in the run state with room in the output register.
  assign in_ready = (state == ST_RUN) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign color    = {in_data.green, in_data.red, in_data.blue};

  // Pixel write address and range check.
  assign wr_index    = 32'(in_data.row) * 32'(LEDS_PER_ROW) + 32'(in_data.column);
  assign wr_in_range = (32'(in_data.row) < 32'(ROWS)) &&
                       (32'(in_data.column) < 32'(LEDS_PER_ROW));

  // One write port: the sweep owns it in its state, pixel writes otherwise.
  always_comb begin
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = fill_color;
    end else begin
      mem_we    = accept && (in_data.kind == KIND_WRITE) && wr_in_range;
      mem_waddr = wr_index[AW-1:0];
      mem_wdata = color;
    end
  end

  // Frame store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_FETCH) begin
      rd_data <= mem[pix_addr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_one  <= DUTY_ONE_RESET;
      duty_zero <= DUTY_ZERO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DUTY_ONE:  duty_one  <= cfg_data;
        REG_DUTY_ZERO: duty_zero <= cfg_data;
        default:       duty_one  <= duty_one;
      endcase
    end
  end

  // Output register: loaded by a tick, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (in_data.kind == KIND_TICK)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.kind == KIND_TICK)) begin
      if (sending) begin
        out_data.duty        <= shift_word[23] ? duty_one : duty_zero;
        out_data.line_active <= 1'b1;
        out_data.frame_last  <= (bit_counter == LAST_BIT) && (pix_addr == LAST_ADDR);
      end else begin
        out_data.duty        <= 8'd0;
        out_data.line_active <= 1'b0;
        out_data.frame_last  <= 1'b0;
      end
    end
  end

  // Sequencer: store sweep, frame pointers and the bit shifter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      fill_color  <= '0;
      pix_addr    <= '0;
      bit_counter <= '0;
      shift_word  <= '0;
      sending     <= 1'b0;
    end else begin
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == LAST_ADDR) begin
            sweep_addr <= '0;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (accept) begin
            case (in_data.kind)
              KIND_FILL: begin
                fill_color <= color;
                sweep_addr <= '0;
                state      <= ST_SWEEP;
              end
              KIND_START: begin
                if (!sending) begin
                  sending     <= 1'b1;
                  pix_addr    <= '0;
                  bit_counter <= '0;
                  state       <= ST_FETCH;
                end
              end
              KIND_TICK: begin
                if (sending) begin
                  shift_word  <= {shift_word[22:0], 1'b0};
                  bit_counter <= bit_counter + 5'd1;
                  // End of a pixel word: finish the frame or fetch the next pixel.
                  if (bit_counter == LAST_BIT) begin
                    bit_counter <= '0;
                    if (pix_addr == LAST_ADDR) begin
                      sending    <= 1'b0;
                      pix_addr   <= '0;
                      shift_word <= '0;
                    end else begin
                      pix_addr <= pix_addr + AW'(1);
                      state    <= ST_FETCH;
                    end
                  end
                end
              end
              default: begin
                state <= ST_RUN;
              end
            endcase
          end
        end
        ST_FETCH: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          shift_word <= rd_data;
          state      <= ST_RUN;
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the addressable LED frame serializer.
`timescale 1ns / 100ps

module tb_top;
  import alfs_pkg::*;

  // Pause long enough to cover a fill walk of the whole frame store.
  localparam int SETTLE_CYCLES = 1100;
  localparam int PHASE_ITEMS   = 390;

  // One row of the directed table: a command, its repeat count and,
  // where it is obvious, the result each repeat must give.
  typedef struct {
    in_beat_t    beat;
    int unsigned reps;
    bit          typed;
    out_beat_t   want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_write;
  logic      cfg_index;
  logic [7:0] cfg_data;

  // Hand-typed expectation that travels with the beat on the input channel.
  bit        hand_check;
  out_beat_t hand_beat;

  bit          no_idle = 1'b0;
  int unsigned mismatch_count = 0;

  // Shadow copy of the frame store, the sequencer and the duty registers.
  logic [23:0] frame_store [0:1023];
  logic [3:0]  row_ptr;
  logic [5:0]  led_ptr;
  int unsigned bit_cnt;
  logic [23:0] shift_reg;
  bit          sending_frame;
  logic [7:0]  duty_one_cur;
  logic [7:0]  duty_zero_cur;

  out_beat_t line_beats_due [$];
  out_beat_t predicted_beat;
  out_beat_t oldest_beat;

  stim_row_t directed_rows [16] = '{
    '{'{KIND_TICK,  4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 1, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_WRITE, 4'd0,  6'd0,  8'h00, 8'hff, 8'ha5}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_WRITE, 4'd0,  6'd1,  8'hff, 8'h00, 8'h00}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_WRITE, 4'd15, 6'd63, 8'hff, 8'hff, 8'hff}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_START, 4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_START, 4'd7,  6'd9,  8'h12, 8'h34, 8'h56}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 48, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_WRITE, 4'd0,  6'd2,  8'h5a, 8'h3c, 8'hc3}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_WRITE, 4'd0,  6'd3,  8'hc3, 8'h5a, 8'h3c}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 24528, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  4'd15, 6'd63, 8'hff, 8'hff, 8'hff}, 1, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_FILL,  4'd0,  6'd0,  8'hff, 8'hff, 8'hff}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_START, 4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 24, 1'b1,
      '{DUTY_ONE_RESET, 1'b1, 1'b0}},
    '{'{KIND_FILL,  4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 1, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  4'd0,  6'd0,  8'h00, 8'h00, 8'h00}, 48, 1'b0, '{8'd0, 1'b0, 1'b0}}
  };

  addressable_led_frame_serializer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Works out the line beat that one command gives; returns 1 if it gives one.
  function automatic bit next_line_beat(input in_beat_t b, output out_beat_t r);
    logic [23:0] color;
    color = {b.green, b.red, b.blue};
    r = '0;
    case (b.kind)
      KIND_WRITE: begin
        frame_store[{b.row, b.column}] = color;
        return 1'b0;
      end
      KIND_FILL: begin
        foreach (frame_store[i]) frame_store[i] = color;
        return 1'b0;
      end
      KIND_START: begin
        // A start during a frame leaves the frame running.
        if (!sending_frame) begin
          row_ptr = '0;
          led_ptr = '0;
          bit_cnt = 0;
          shift_reg = frame_store[0];
          sending_frame = 1'b1;
        end
        return 1'b0;
      end
      default: ;
    endcase
    // An idle tick holds the line low.
    if (!sending_frame) return 1'b1;
    r.duty = shift_reg[23] ? duty_one_cur : duty_zero_cur;
    r.line_active = 1'b1;
    shift_reg = shift_reg << 1;
    bit_cnt++;
    if (bit_cnt == WORD_BITS) begin
      bit_cnt = 0;
      if (led_ptr == 6'd63) begin
        led_ptr = '0;
        if (row_ptr == 4'd15) begin
          r.frame_last = 1'b1;
          sending_frame = 1'b0;
          row_ptr = '0;
          shift_reg = '0;
        end else begin
          row_ptr++;
        end
      end else begin
        led_ptr++;
      end
      // The next word is taken from the store on the tick that ends the previous word.
      if (sending_frame) shift_reg = frame_store[{row_ptr, led_ptr}];
    end
    return 1'b1;
  endfunction

  // Random command, mostly ticks, with writes often aimed just ahead of the sequencer.
  function automatic in_beat_t random_item();
    in_beat_t    b;
    int unsigned pick;
    logic [9:0]  spot;
    b.row    = 4'($urandom);
    b.column = 6'($urandom);
    b.red    = 8'($urandom);
    b.green  = 8'($urandom);
    b.blue   = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 62) begin
      b.kind = KIND_TICK;
    end else if (pick < 88) begin
      b.kind = KIND_WRITE;
      if ($urandom_range(1) == 1) begin
        spot = {row_ptr, led_ptr} + 10'($urandom_range(2));
        {b.row, b.column} = spot;
      end
    end else if (pick < 97) begin
      b.kind = KIND_START;
    end else begin
      b.kind = KIND_FILL;
    end
    return b;
  endfunction

  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Offers one command and holds it until the block takes it.
  task automatic send_item(input in_beat_t b, input bit typed, input out_beat_t want);
    if (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!no_idle && $urandom_range(99) < 35);
    end
    in_valid   <= 1'b1;
    in_data    <= b;
    hand_check <= typed;
    hand_beat  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lets every expected beat arrive and any fill walk finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_duties(input logic [7:0] one_val, input logic [7:0] zero_val);
    cfg_write <= 1'b1;
    cfg_index <= REG_DUTY_ONE;
    cfg_data  <= one_val;
    @(posedge clk);
    cfg_index <= REG_DUTY_ZERO;
    cfg_data  <= zero_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    duty_one_cur  = one_val;
    duty_zero_cur = zero_val;
  endtask

  // Receiver: stalls at random except during the stretch with no idling.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 35);
  end

  // Predicts on every accepted command and checks every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready && next_line_beat(in_data, predicted_beat)) begin
        line_beats_due.push_back(hand_check ? hand_beat : predicted_beat);
      end
      if (out_valid && out_ready) begin
        if (line_beats_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with none expected, actual duty %0d active %0b last %0b",
                   $time, out_data.duty, out_data.line_active, out_data.frame_last);
        end else begin
          oldest_beat = line_beats_due.pop_front();
          report_field("duty", oldest_beat.duty, out_data.duty);
          report_field("line_active", 8'(oldest_beat.line_active),
                       8'(out_data.line_active));
          report_field("frame_last", 8'(oldest_beat.frame_last),
                       8'(out_data.frame_last));
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases under several duty settings.
  initial begin
    in_beat_t    b;
    int unsigned sent;
    logic [7:0]  phase_one [5];
    logic [7:0]  phase_zero [5];

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_data    <= '0;
    hand_check <= 1'b0;
    hand_beat  <= '0;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_DUTY_ONE;
    cfg_data   <= '0;
    foreach (frame_store[i]) frame_store[i] = '0;
    row_ptr       = '0;
    led_ptr       = '0;
    bit_cnt       = 0;
    shift_reg     = '0;
    sending_frame = 1'b0;
    duty_one_cur  = DUTY_ONE_RESET;
    duty_zero_cur = DUTY_ZERO_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_duties(DUTY_ONE_RESET, DUTY_ZERO_RESET);

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps) begin
        send_item(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Extremes first, then random, near-extreme and random settings; the middle phase never idles.
    phase_one  = '{8'd255, 8'd0,   8'($urandom), 8'd1,   8'($urandom)};
    phase_zero = '{8'd0,   8'd255, 8'($urandom), 8'd254, 8'($urandom)};
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      set_duties(phase_one[phase], phase_zero[phase]);
      no_idle = (phase == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        b = random_item();
        if (!(b.kind == KIND_START && sending_frame)) sent++;
        send_item(b, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    // Run the frame in progress to its last bit, with writes mixed in.
    while (sending_frame) begin
      b = random_item();
      if (b.kind != KIND_WRITE) b.kind = KIND_TICK;
      send_item(b, 1'b0, '0);
    end
    repeat (40) send_item(random_item(), 1'b0, '0);

    settle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
